/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// implication check, antecedent and consequent given apart
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mfd_pkg.sv */
package mfd_pkg;

  localparam int unsigned WIN_DEPTH = 7;
  localparam int unsigned ADDR_W    = 8 * (WIN_DEPTH - 1);

  localparam logic [7:0] HDR_MARK       = 8'h68;
  localparam logic [7:0] END_MARK       = 8'h16;
  localparam logic [7:0] PAYLOAD_OFFSET = 8'h33;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_DONE    = 2'd1,
    EV_REJECT  = 2'd2
  } event_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_CTRL = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CSUM = 6'b010000,
    PH_END  = 6'b100000
  } phase_t;

  typedef struct packed {
    event_t              event_res;
    logic [7:0]          payload_byte;
    logic [7:0]          byte_index;
    logic [ADDR_W-1:0]   meter_address;
    logic [7:0]          control_code;
    logic [7:0]          payload_length;
    logic                last;
  } result_t;

endpackage

/* hw/rtl/meter_frame_deframer_top.sv */
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// in_       | input     | in_valid/in_ready  | rx_byte
// out_      | output    | out_valid/out_ready| event_res, payload_byte, byte_index,
//           |           |                    | meter_address, control_code,
//           |           |                    | payload_length, last
//
// one item is taken per cycle while in_ready is high; any result is registered onto out_
// the parse state updates in the cycle the item is accepted, feeding a result register
// a skid register behind the result register parks one more item while the result stalls
// in_ready drops only while both the result and skid registers hold an item
// rst_n is synchronous, active low, and returns the parser to header hunting
`include "assert_macros.svh"

module meter_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_byte_index,
  output logic [47:0] out_meter_address,
  output logic [7:0]  out_control_code,
  output logic [7:0]  out_payload_length,
  output logic        out_last
);

  // parse state
  mfd_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                  win_r   [mfd_pkg::WIN_DEPTH];
  logic [7:0]                  win_nxt [mfd_pkg::WIN_DEPTH];
  logic [mfd_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [7:0]                  ctrl_r, ctrl_nxt;
  logic [7:0]                  len_r, len_nxt;
  logic [7:0]                  cnt_r, cnt_nxt;

  // result register and skid stage
  mfd_pkg::result_t            out_r, out_nxt;
  mfd_pkg::result_t            skid_r, skid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;

  mfd_pkg::result_t            res;
  logic                        res_valid;
  logic                        acc;
  logic                        pop;
  logic                        push;
  logic [7:0]                  cnt_inc;
  logic [mfd_pkg::ADDR_W-1:0]  win_addr;

  assign in_ready = !skid_valid_r;
  assign acc      = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign push     = acc && res_valid;
  assign cnt_inc  = cnt_r + 8'd1;

  // address bytes sit in window slots 1..6, oldest first
  always_comb begin
    for (int k = 1; k < mfd_pkg::WIN_DEPTH; k++) begin
      win_addr[8*(k-1) +: 8] = win_r[k];
    end
  end

  // parse step for the item at the input
  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    addr_nxt  = addr_r;
    ctrl_nxt  = ctrl_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res.event_res      = mfd_pkg::EV_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.byte_index     = 8'd0;
    res.meter_address  = addr_r;
    res.control_code   = ctrl_r;
    res.payload_length = len_r;
    res.last           = 1'b0;

    unique case (phase_r)
      mfd_pkg::PH_CTRL: begin
        ctrl_nxt  = in_rx_byte;
        phase_nxt = mfd_pkg::PH_LEN;
      end
      mfd_pkg::PH_LEN: begin
        len_nxt   = in_rx_byte;
        cnt_nxt   = 8'd0;
        // zero length goes straight to the checksum
        phase_nxt = (in_rx_byte == 8'd0) ? mfd_pkg::PH_CSUM : mfd_pkg::PH_DATA;
      end
      mfd_pkg::PH_DATA: begin
        res_valid        = 1'b1;
        res.payload_byte = in_rx_byte - mfd_pkg::PAYLOAD_OFFSET;
        res.byte_index   = cnt_r;
        cnt_nxt          = cnt_inc;
        if (cnt_inc == len_r) begin
          phase_nxt = mfd_pkg::PH_CSUM;
        end
      end
      mfd_pkg::PH_CSUM: begin
        // checksum is skipped, not checked
        phase_nxt = mfd_pkg::PH_END;
      end
      mfd_pkg::PH_END: begin
        res_valid     = 1'b1;
        res.event_res = (in_rx_byte == mfd_pkg::END_MARK) ? mfd_pkg::EV_DONE
                                                          : mfd_pkg::EV_REJECT;
        res.last      = 1'b1;
        for (int k = 0; k < mfd_pkg::WIN_DEPTH; k++) begin
          win_nxt[k] = 8'd0;
        end
        phase_nxt = mfd_pkg::PH_HUNT;
      end
      default: begin
        // hunting, also covers codes that never occur
        phase_nxt = mfd_pkg::PH_HUNT;
        if (in_rx_byte == mfd_pkg::HDR_MARK && win_r[0] == mfd_pkg::HDR_MARK) begin
          addr_nxt = win_addr;
          for (int k = 0; k < mfd_pkg::WIN_DEPTH; k++) begin
            win_nxt[k] = 8'd0;
          end
          phase_nxt = mfd_pkg::PH_CTRL;
        end else begin
          for (int k = 0; k < mfd_pkg::WIN_DEPTH - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          win_nxt[mfd_pkg::WIN_DEPTH-1] = in_rx_byte;
        end
      end
    endcase
  end

  // result register with one skid entry behind it
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      // no push can happen here since in_ready is low
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      if (push) begin
        out_nxt = res;
      end
    end else if (push) begin
      // result register stalled, park the new item
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mfd_pkg::PH_HUNT;
      addr_r       <= '0;
      ctrl_r       <= 8'd0;
      len_r        <= 8'd0;
      cnt_r        <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int k = 0; k < mfd_pkg::WIN_DEPTH; k++) begin
        win_r[k] <= 8'd0;
      end
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (acc) begin
        phase_r <= phase_nxt;
        addr_r  <= addr_nxt;
        ctrl_r  <= ctrl_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        win_r   <= win_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_r.event_res;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_byte_index     = out_r.byte_index;
  assign out_meter_address  = out_r.meter_address;
  assign out_control_code   = out_r.control_code;
  assign out_payload_length = out_r.payload_length;
  assign out_last           = out_r.last;

  // skid entry only fills behind a held result
  `ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full while result register empty")
  // a stalled result is never dropped
  `ASSERT_CLK(a_hold_stalled, out_valid_r && !out_ready |=> out_valid_r, "stalled result lost")
  // last marks exactly the frame-end events
  `ASSERT_IMPL(a_last_match, out_valid_r, out_r.last == (out_r.event_res != mfd_pkg::EV_PAYLOAD), "last flag disagrees with event")
  // payload index stays inside the declared length
  `ASSERT_IMPL(a_cnt_in_len, phase_r == mfd_pkg::PH_DATA, cnt_r < len_r, "byte count beyond payload length")

endmodule

/* test/tb_meter_frame_deframer_top.sv */
module tb_meter_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // generous watchdog for ~900 items, even with random idle gaps on the sender
  // and stall bursts on the receiver
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_event_res;
  logic [7:0]        out_payload_byte;
  logic [7:0]        out_byte_index;
  logic [47:0]       out_meter_address;
  logic [7:0]        out_control_code;
  logic [7:0]        out_payload_length;
  logic              out_last;

  // shadow of the parser state, advanced once per accepted item
  logic [7:0]                 hunt_win [mfd_pkg::WIN_DEPTH];
  mfd_pkg::phase_t            parse_ph;
  logic [mfd_pkg::ADDR_W-1:0] frame_addr;
  logic [7:0]                 frame_ctrl;
  logic [7:0]                 frame_len;
  logic [7:0]                 pay_count;

  // frame events still owed by the block, oldest first
  mfd_pkg::result_t  events_due [$];

  int unsigned       mismatches;
  int unsigned       items_sent;
  int unsigned       cycle_count;
  bit                src_gaps;
  bit                sink_stalls;

  meter_frame_deframer_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_payload_byte   (out_payload_byte),
    .out_byte_index     (out_byte_index),
    .out_meter_address  (out_meter_address),
    .out_control_code   (out_control_code),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame event predictor
  // ---------------------------------------------------------------------------

  // snapshot of the held frame fields goes out with every event
  function automatic void queue_event(input mfd_pkg::event_t ev, input logic [7:0] pay,
                                      input logic [7:0] idx, input logic lst);
    mfd_pkg::result_t r;
    r.event_res      = ev;
    r.payload_byte   = pay;
    r.byte_index     = idx;
    r.meter_address  = frame_addr;
    r.control_code   = frame_ctrl;
    r.payload_length = frame_len;
    r.last           = lst;
    events_due.push_back(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    int k;
    case (parse_ph)
      mfd_pkg::PH_CTRL: begin
        frame_ctrl = b;
        parse_ph   = mfd_pkg::PH_LEN;
      end
      mfd_pkg::PH_LEN: begin
        frame_len = b;
        pay_count = 8'h00;
        // zero length goes straight to the checksum byte
        parse_ph  = (b == 8'h00) ? mfd_pkg::PH_CSUM : mfd_pkg::PH_DATA;
      end
      mfd_pkg::PH_DATA: begin
        queue_event(mfd_pkg::EV_PAYLOAD, b - mfd_pkg::PAYLOAD_OFFSET, pay_count, 1'b0);
        pay_count = pay_count + 8'd1;
        if (pay_count == frame_len) parse_ph = mfd_pkg::PH_CSUM;
      end
      mfd_pkg::PH_CSUM: begin
        // checksum is not checked, only skipped
        parse_ph = mfd_pkg::PH_END;
      end
      mfd_pkg::PH_END: begin
        if (b == mfd_pkg::END_MARK) begin
          queue_event(mfd_pkg::EV_DONE, 8'h00, 8'h00, 1'b1);
        end else begin
          queue_event(mfd_pkg::EV_REJECT, 8'h00, 8'h00, 1'b1);
        end
        // closing byte never enters the window, good or bad
        for (k = 0; k < mfd_pkg::WIN_DEPTH; k++) hunt_win[k] = 8'h00;
        parse_ph = mfd_pkg::PH_HUNT;
      end
      default: begin
        parse_ph = mfd_pkg::PH_HUNT;
        if (b == mfd_pkg::HDR_MARK && hunt_win[0] == mfd_pkg::HDR_MARK) begin
          // newest address byte lands on top, first received at the bottom
          frame_addr = '0;
          for (k = mfd_pkg::WIN_DEPTH - 1; k >= 1; k--) begin
            frame_addr = {frame_addr[mfd_pkg::ADDR_W-9:0], hunt_win[k]};
          end
          for (k = 0; k < mfd_pkg::WIN_DEPTH; k++) hunt_win[k] = 8'h00;
          parse_ph = mfd_pkg::PH_CTRL;
        end else begin
          for (k = 0; k < mfd_pkg::WIN_DEPTH - 1; k++) hunt_win[k] = hunt_win[k+1];
          hunt_win[mfd_pkg::WIN_DEPTH-1] = b;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // drives one item and holds it until accepted; valid stays high afterwards
  // so a following call can go back to back without touching it
  task automatic send_byte(input logic [7:0] b);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    items_sent++;
  endtask

  // whole frame on the wire: header, address, header, control, length, payload, checksum, end
  task automatic send_frame(input logic [mfd_pkg::ADDR_W-1:0] addr, input logic [7:0] ctrl,
                            input logic [7:0] len, input logic [7:0] tail);
    int unsigned k;
    send_byte(mfd_pkg::HDR_MARK);
    for (k = 0; k < mfd_pkg::WIN_DEPTH - 1; k++) send_byte(addr[8*k +: 8]);
    send_byte(mfd_pkg::HDR_MARK);
    send_byte(ctrl);
    send_byte(len);
    for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(tail);
  endtask

  // random frame, mostly short and mostly well closed
  task automatic send_random_frame();
    logic [63:0]                rnd;
    logic [mfd_pkg::ADDR_W-1:0] addr;
    logic [7:0]                 len;
    logic [7:0]                 tail;
    rnd  = {$urandom, $urandom};
    addr = rnd[mfd_pkg::ADDR_W-1:0];
    // a marker byte inside the address must not confuse the header match
    if ($urandom_range(0, 3) == 0) addr[8*$urandom_range(0, 5) +: 8] = mfd_pkg::HDR_MARK;
    len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 24))
                                       : 8'($urandom_range(0, 5));
    tail = mfd_pkg::END_MARK;
    if ($urandom_range(0, 3) == 0) begin
      tail = ($urandom_range(0, 1) == 0) ? mfd_pkg::HDR_MARK : 8'($urandom_range(0, 255));
    end
    send_frame(addr, 8'($urandom_range(0, 255)), len, tail);
  endtask

  // sender holds off until every owed event has come back
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // receiver stalls in bursts while enabled
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every accepted result against the oldest owed event
  always @(posedge clk) begin : result_check
    mfd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        $display("%0t: result with nothing owed, actual event %0d payload %0h",
                 $time, out_event_res, out_payload_byte);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        check_field("event_res",      48'(want.event_res),      48'(out_event_res));
        check_field("payload_byte",   48'(want.payload_byte),   48'(out_payload_byte));
        check_field("byte_index",     48'(want.byte_index),     48'(out_byte_index));
        check_field("meter_address",  want.meter_address,       out_meter_address);
        check_field("control_code",   48'(want.control_code),   48'(out_control_code));
        check_field("payload_length", 48'(want.payload_length), 48'(out_payload_length));
        check_field("last",           48'(want.last),           48'(out_last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still owed", cycle_count,
               events_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero length, good end, address with extreme bytes and an inner marker
  task automatic test_zero_length_frame();
    send_byte(mfd_pkg::HDR_MARK);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mfd_pkg::HDR_MARK);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h01);
    send_byte(mfd_pkg::HDR_MARK);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mfd_pkg::END_MARK);
  endtask

  // payload wraps below the offset, then a bad end marker that is itself a header byte
  task automatic test_payload_reject();
    int k;
    send_byte(mfd_pkg::HDR_MARK);
    for (k = 0; k < mfd_pkg::WIN_DEPTH - 1; k++) send_byte(8'hFF);
    send_byte(mfd_pkg::HDR_MARK);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(mfd_pkg::PAYLOAD_OFFSET - 8'd1);
    send_byte(mfd_pkg::PAYLOAD_OFFSET);
    send_byte(8'h00);
    send_byte(mfd_pkg::HDR_MARK);
  endtask

  // the rejected byte must not sit in the window: seven later bytes ending in
  // a marker would match only if it did
  task automatic test_reject_byte_not_hunted();
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h66);
    send_byte(mfd_pkg::HDR_MARK);
  endtask

  // frames with random content, mostly well closed, stray bytes now and then
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
      send_random_frame();
    end
  endtask

  // longest declared payload, index runs up to 254
  task automatic test_longest_frame();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    send_frame(rnd[mfd_pkg::ADDR_W-1:0], 8'($urandom_range(0, 255)), 8'hFF,
               mfd_pkg::END_MARK);
  endtask

  // line noise biased toward markers, cut headers, and some real frames
  task automatic test_noise_and_broken(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned k;
    int unsigned n;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 2))
        0: begin
          // header cut short, then a marker in the wrong slot
          send_byte(mfd_pkg::HDR_MARK);
          n = $urandom_range(0, 5);
          for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
          send_byte(mfd_pkg::HDR_MARK);
        end
        1: begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) begin
            send_byte(($urandom_range(0, 3) == 0) ? mfd_pkg::HDR_MARK
                                                  : 8'($urandom_range(0, 255)));
          end
        end
        default: send_random_frame();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    mismatches  = 0;
    items_sent  = 0;
    cycle_count = 0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    for (k = 0; k < mfd_pkg::WIN_DEPTH; k++) hunt_win[k] = 8'h00;
    parse_ph   = mfd_pkg::PH_HUNT;
    frame_addr = '0;
    frame_ctrl = 8'h00;
    frame_len  = 8'h00;
    pay_count  = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_length_frame();
    test_payload_reject();
    test_reject_byte_not_hunted();
    drain_events();

    test_random_frames(350);
    drain_events();
    test_longest_frame();
    test_noise_and_broken(150);
    drain_events();

    // closing stretch at full rate on both sides
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    test_random_frames(80);

    drain_events();
    // result register plus skid register, with margin
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
